// ----- design/mvm_pkg.sv -----
// shared types and codes for the matrix vector multiply block
package mvm_pkg;

	// operation codes carried in the input tuser
	typedef enum logic [1:0] {
		OP_WRITE_MATRIX = 2'd0,
		OP_WRITE_VECTOR = 2'd1,
		OP_MULTIPLY     = 2'd2,
		OP_ROW_SUM      = 2'd3
	} mvm_op_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW_START,
		ST_ISSUE,
		ST_DRAIN
	} mvm_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic write_matrix; // store input value in the matrix
		logic write_vector; // store input value in the vector
		logic issue;        // read one element pair this cycle
		logic first;        // first element of a row, clears the accumulator
		logic last;         // last element of a row
		logic row_sum;      // magnitude and sum instead of multiply
		logic op_last;      // this row gives the operation's final item
	} mvm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic done;     // a row result is loaded in the output register
		logic out_busy; // output register stays full next cycle
	} mvm_status_t;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned FIELD_W = 4;
	localparam int unsigned SIZE_W  = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

// ----- design/mvm_ram.sv -----
// generic single write port ram with registered read
module mvm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- design/mvm_ctrl.sv -----
// controller state machine: order, row and column sequencing
module mvm_ctrl #(
	parameter int unsigned MAX_ORDER = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [mvm_pkg::SIZE_W-1:0]             cfg_wr_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             in_op,
	input  logic [mvm_pkg::FIELD_W-1:0]            in_row,
	output mvm_pkg::mvm_cmd_t                      cmd,
	output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_row,
	output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_col,
	input  mvm_pkg::mvm_status_t                   status
);

	localparam int unsigned IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int unsigned NW = $clog2(MAX_ORDER + 1);

	mvm_pkg::mvm_state_t state_q, state_d;
	mvm_pkg::mvm_op_t    op_q;
	logic [mvm_pkg::SIZE_W-1:0] size_q;
	logic [IW-1:0] row_q, col_q, last_idx;
	logic [NW-1:0] order;
	logic          accept, row_ok, more_rows;

	// order in use, clamped to one and MAX_ORDER
	always_comb begin
		if (size_q == '0) begin
			order = NW'(1);
		end else if (32'(size_q) > MAX_ORDER) begin
			order = NW'(MAX_ORDER);
		end else begin
			order = NW'(size_q);
		end
	end

	assign last_idx  = IW'(order - NW'(1));
	assign accept    = in_valid && in_ready;
	assign row_ok    = 32'(in_row) < 32'(order);
	assign more_rows = (op_q == mvm_pkg::OP_MULTIPLY) && (row_q != last_idx);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mvm_pkg::ST_IDLE: begin
				if (accept && (in_op == mvm_pkg::OP_MULTIPLY ||
				               (in_op == mvm_pkg::OP_ROW_SUM && row_ok))) begin
					state_d = mvm_pkg::ST_ROW_START;
				end
			end
			mvm_pkg::ST_ROW_START: begin
				if (!status.out_busy) begin
					state_d = mvm_pkg::ST_ISSUE;
				end
			end
			mvm_pkg::ST_ISSUE: begin
				if (col_q == last_idx) begin
					state_d = mvm_pkg::ST_DRAIN;
				end
			end
			mvm_pkg::ST_DRAIN: begin
				if (status.done) begin
					state_d = more_rows ? mvm_pkg::ST_ROW_START : mvm_pkg::ST_IDLE;
				end
			end
			default: state_d = mvm_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		rd_row   = row_q;
		rd_col   = col_q;
		case (state_q)
			mvm_pkg::ST_IDLE: begin
				in_ready         = 1'b1;
				cmd.write_matrix = in_valid && (in_op == mvm_pkg::OP_WRITE_MATRIX);
				cmd.write_vector = in_valid && (in_op == mvm_pkg::OP_WRITE_VECTOR);
			end
			mvm_pkg::ST_ISSUE: begin
				cmd.issue   = 1'b1;
				cmd.first   = (col_q == '0);
				cmd.last    = (col_q == last_idx);
				cmd.row_sum = (op_q == mvm_pkg::OP_ROW_SUM);
				cmd.op_last = (op_q == mvm_pkg::OP_ROW_SUM) || (row_q == last_idx);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mvm_pkg::ST_IDLE;
			op_q    <= mvm_pkg::OP_WRITE_MATRIX;
			size_q  <= mvm_pkg::SIZE_RESET;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			case (state_q)
				mvm_pkg::ST_IDLE: begin
					if (accept) begin
						op_q  <= mvm_pkg::mvm_op_t'(in_op);
						row_q <= (in_op == mvm_pkg::OP_ROW_SUM) ? IW'(in_row) : '0;
					end
				end
				mvm_pkg::ST_ROW_START: col_q <= '0;
				mvm_pkg::ST_ISSUE:     col_q <= col_q + IW'(1);
				mvm_pkg::ST_DRAIN: begin
					if (status.done && more_rows) begin
						row_q <= row_q + IW'(1);
					end
				end
				default: col_q <= '0;
			endcase
		end
	end

endmodule

// ----- design/mvm_datapath.sv -----
// datapath: element stores, multiply-accumulate, scaling and result register
module mvm_datapath #(
	parameter int unsigned MAX_ORDER     = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mvm_pkg::mvm_cmd_t                      cmd,
	input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_row,
	input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_col,
	input  logic [mvm_pkg::FIELD_W-1:0]            in_row,
	input  logic [mvm_pkg::FIELD_W-1:0]            in_col,
	input  logic [mvm_pkg::DATA_W-1:0]             in_value,
	output mvm_pkg::mvm_status_t                   status,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mvm_pkg::DATA_W-1:0]             result_value,
	output logic [mvm_pkg::FIELD_W-1:0]            result_index,
	output logic                                   result_last
);

	localparam int unsigned IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int unsigned AW    = 2 * IW;
	localparam int unsigned ACC_W = 2 * mvm_pkg::DATA_W + IW + 1;

	// store access
	logic                        row_ok, col_ok, wb_en;
	logic                        mat_wr_en, vec_wr_en;
	logic [AW-1:0]               mat_wr_addr;
	logic [mvm_pkg::DATA_W-1:0]  mat_wr_data, mat_rdata, vec_rdata;

	// stage 1: read data returning
	logic                        valid_s1, first_s1, last_s1, rowsum_s1, oplast_s1;
	logic [IW-1:0]               row_s1, col_s1;
	logic signed [mvm_pkg::DATA_W-1:0]   mat_s, vec_s, mag;
	logic signed [2*mvm_pkg::DATA_W-1:0] product, term;

	// stage 2: product registered
	logic                        valid_s2, first_s2, last_s2, rowsum_s2, oplast_s2;
	logic [IW-1:0]               row_s2;
	logic signed [2*mvm_pkg::DATA_W-1:0] term_s2;
	logic signed [ACC_W-1:0]     acc_q;

	// stage 3: row complete
	logic                        fin_s3, rowsum_s3, oplast_s3;
	logic [IW-1:0]               row_s3;
	logic signed [ACC_W-1:0]     scaled;
	logic [ACC_W-32:0]           scaled_hi;
	logic [ACC_W-32:0]           acc_hi;
	logic [mvm_pkg::DATA_W-1:0]  mult_sat, sum_sat;
	logic                        out_valid_q;

	assign row_ok = 32'(in_row) < MAX_ORDER;
	assign col_ok = 32'(in_col) < MAX_ORDER;

	// row-sum write back of a negative entry's magnitude has the port
	assign wb_en       = valid_s1 && rowsum_s1 && mat_s[mvm_pkg::DATA_W-1];
	assign mat_wr_en   = wb_en || (cmd.write_matrix && row_ok && col_ok);
	assign mat_wr_addr = wb_en ? {row_s1, col_s1} : {IW'(in_row), IW'(in_col)};
	assign mat_wr_data = wb_en ? mag : in_value;
	assign vec_wr_en   = cmd.write_vector && col_ok;

	mvm_ram #(
		.WIDTH(mvm_pkg::DATA_W),
		.DEPTH(2 ** AW)
	) u_matrix_ram (
		.clk    (clk),
		.wr_en  (mat_wr_en),
		.wr_addr(mat_wr_addr),
		.wr_data(mat_wr_data),
		.rd_addr({rd_row, rd_col}),
		.rd_data(mat_rdata)
	);

	mvm_ram #(
		.WIDTH(mvm_pkg::DATA_W),
		.DEPTH(MAX_ORDER)
	) u_vector_ram (
		.clk    (clk),
		.wr_en  (vec_wr_en),
		.wr_addr(IW'(in_col)),
		.wr_data(in_value),
		.rd_addr(rd_col),
		.rd_data(vec_rdata)
	);

	assign mat_s   = mat_rdata;
	assign vec_s   = vec_rdata;
	assign product = mat_s * vec_s;

	// magnitude, most negative value saturates
	always_comb begin
		if (!mat_s[mvm_pkg::DATA_W-1]) begin
			mag = mat_s;
		end else if (mat_rdata == mvm_pkg::SAT_MIN) begin
			mag = mvm_pkg::SAT_MAX;
		end else begin
			mag = -mat_s;
		end
	end

	assign term = rowsum_s1 ? {{mvm_pkg::DATA_W{1'b0}}, mag} : product;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			fin_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			fin_s3   <= valid_s2 && last_s2;
			if (fin_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= cmd.first;
		last_s1   <= cmd.last;
		rowsum_s1 <= cmd.row_sum;
		oplast_s1 <= cmd.op_last;
		row_s1    <= rd_row;
		col_s1    <= rd_col;

		term_s2   <= term;
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		rowsum_s2 <= rowsum_s1;
		oplast_s2 <= oplast_s1;
		row_s2    <= row_s1;

		if (valid_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + ACC_W'(term_s2);
		end

		rowsum_s3 <= rowsum_s2;
		oplast_s3 <= oplast_s2;
		row_s3    <= row_s2;

		if (fin_s3) begin
			result_value <= rowsum_s3 ? sum_sat : mult_sat;
			result_index <= mvm_pkg::FIELD_W'(row_s3);
			result_last  <= oplast_s3;
		end
	end

	// floor shift then clamp to 32 bits
	assign scaled    = acc_q >>> FRACTION_BITS;
	assign scaled_hi = scaled[ACC_W-1:31];
	assign acc_hi    = acc_q[ACC_W-1:31];

	always_comb begin
		if ((&scaled_hi) || !(|scaled_hi)) begin
			mult_sat = scaled[31:0];
		end else if (scaled[ACC_W-1]) begin
			mult_sat = mvm_pkg::SAT_MIN;
		end else begin
			mult_sat = mvm_pkg::SAT_MAX;
		end
	end

	assign sum_sat = (|acc_hi) ? mvm_pkg::SAT_MAX : acc_q[31:0];

	assign out_valid       = out_valid_q;
	assign status.done     = fin_s3;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

// ----- design/matrix_vector_multiply.sv -----
// top level of the dense matrix vector multiply block
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: operation, tdata: row, col, value
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result_value, result_index; tlast
// cfg       in   cfg_wr_en                      cfg_wr_data: size_in_use
//
// element writes give no item; ready stays high between them
// a multiply runs row by row: a start state, then n element reads of one shared
// multiply-accumulate over one read port per ram, then product, sum and scaling
// a row sum gives one item; a row at or above n gives no item
// a row starts only when the output register is free, so a stalled output holds the
// next row; after the final item is loaded the block takes new input items again
// reset clears control state and sets the order to 16; stored elements are undefined
module matrix_vector_multiply #(
	parameter int unsigned MAX_ORDER     = 16,
	parameter int unsigned FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration: order in use
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,   // size_in_use

	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row [3:0], col [7:4], value [39:8]
	input  logic [1:0]  s_axis_tuser,  // operation [1:0]

	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // result_value [31:0], result_index [35:32], zero
	output logic        m_axis_tlast   // last
);

	localparam int unsigned IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	mvm_pkg::mvm_cmd_t    cmd;
	mvm_pkg::mvm_status_t status;
	logic [IW-1:0]        rd_row, rd_col;
	logic [31:0]          result_value;
	logic [3:0]           result_index;

	// sequencing of rows and columns
	mvm_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_row     (s_axis_tdata[3:0]),
		.cmd        (cmd),
		.rd_row     (rd_row),
		.rd_col     (rd_col),
		.status     (status)
	);

	// stores, multiply-accumulate and result register
	mvm_datapath #(
		.MAX_ORDER    (MAX_ORDER),
		.FRACTION_BITS(FRACTION_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_row      (rd_row),
		.rd_col      (rd_col),
		.in_row      (s_axis_tdata[3:0]),
		.in_col      (s_axis_tdata[7:4]),
		.in_value    (s_axis_tdata[39:8]),
		.status      (status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.result_value(result_value),
		.result_index(result_index),
		.result_last (m_axis_tlast)
	);

	// pack the result item, zero fill to whole bytes
	assign m_axis_tdata = {4'b0000, result_index, result_value};

endmodule

// ----- dv/matrix_vector_multiply_test.sv -----
// self-checking stream testbench for the matrix vector multiply block
`timescale 1ns / 1ps

module matrix_vector_multiply_test;

	localparam int MAX_ORDER    = 16;
	localparam int FRAC_BITS    = 16;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 3 * (MAX_ORDER + 5);
	localparam int HOLD_CYCLES  = 400;
	localparam logic signed [71:0] ACC_HI = 72'sh7FFF_FFFF;
	localparam logic signed [71:0] ACC_LO = -72'sh8000_0000;

	typedef enum logic [1:0] {
		STEP_SIZE,      // write the order register
		STEP_ITEM,      // item checked against the predictor
		STEP_ITEM_ONE,  // item with one result given in the table
		STEP_ITEM_NONE  // item that must give no result
	} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		logic [4:0]        size;
		mvm_pkg::mvm_op_t  op;
		logic [3:0]        row;
		logic [3:0]        col;
		logic [31:0]       value;
		logic [31:0]       want;
	} step_t;

	typedef struct packed {
		logic [31:0] value;
		logic [3:0]  index;
		logic        last;
	} mvm_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	// shadow of the block's stores and order register
	logic signed [31:0] matrix_shadow [MAX_ORDER*MAX_ORDER];
	logic signed [31:0] vector_shadow [MAX_ORDER];
	bit                 mat_written [MAX_ORDER*MAX_ORDER];
	bit                 vec_written [MAX_ORDER];
	logic [4:0]         size_shadow = mvm_pkg::SIZE_RESET;

	mvm_result_t fresh_results [MAX_ORDER];
	mvm_result_t awaited_results [$];
	mvm_result_t head_result;
	step_t       plan [$];

	int fail_count = 0;
	int result_count = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit output_hold = 1'b0;
	bit hold_go = 1'b0;

	matrix_vector_multiply #(
		.MAX_ORDER(MAX_ORDER),
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int order_of(logic [4:0] size);
		if (size == 0) return 1;
		if (size > MAX_ORDER) return MAX_ORDER;
		return int'(size);
	endfunction

	// updates the shadow state for one item and leaves its results in fresh_results
	function automatic int predict_item(mvm_pkg::mvm_op_t op, logic [3:0] row,
			logic [3:0] col, logic [31:0] value);
		int n;
		logic signed [71:0] acc;
		logic signed [71:0] wide;
		logic signed [31:0] elem;
		longint total;
		n = order_of(size_shadow);
		case (op)
			mvm_pkg::OP_WRITE_MATRIX: begin
				matrix_shadow[int'(row)*MAX_ORDER + int'(col)] = value;
				mat_written[int'(row)*MAX_ORDER + int'(col)] = 1'b1;
				return 0;
			end
			mvm_pkg::OP_WRITE_VECTOR: begin
				vector_shadow[col] = value;
				vec_written[col] = 1'b1;
				return 0;
			end
			mvm_pkg::OP_MULTIPLY: begin
				for (int i = 0; i < n; i++) begin
					acc = '0;
					for (int j = 0; j < n; j++)
						acc += matrix_shadow[i*MAX_ORDER + j] * vector_shadow[j];
					// arithmetic shift floors toward minus infinity
					wide = acc >>> FRAC_BITS;
					fresh_results[i] = '{
						value: (wide > ACC_HI) ? mvm_pkg::SAT_MAX :
							(wide < ACC_LO) ? mvm_pkg::SAT_MIN : wide[31:0],
						index: 4'(i),
						last: (i == n - 1)
					};
				end
				return n;
			end
			default: begin
				if (int'(row) >= n) return 0;
				total = 0;
				for (int j = 0; j < n; j++) begin
					elem = matrix_shadow[int'(row)*MAX_ORDER + j];
					if (elem < 0) begin
						elem = (elem == mvm_pkg::SAT_MIN) ? mvm_pkg::SAT_MAX : -elem;
						matrix_shadow[int'(row)*MAX_ORDER + j] = elem;
					end
					total += elem;
				end
				if (total > longint'(mvm_pkg::SAT_MAX)) total = longint'(mvm_pkg::SAT_MAX);
				fresh_results[0] = '{value: total[31:0], index: row, last: 1'b1};
				return 1;
			end
		endcase
	endfunction

	function automatic int draw_gap(bit idle_on);
		return idle_on ? int'($urandom_range(0, 10)) : 0;
	endfunction

	function automatic logic [31:0] rand_element();
		case ($urandom_range(0, 9))
			0: return mvm_pkg::SAT_MAX;
			1: return mvm_pkg::SAT_MIN;
			2: return '0;
			3: return $urandom;
			default: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
		endcase
	endfunction

	// mostly inside the order in use, sometimes anywhere
	function automatic logic [3:0] pick_index(int n);
		if ($urandom_range(0, 3) != 0) return 4'($urandom_range(0, n - 1));
		return 4'($urandom_range(0, MAX_ORDER - 1));
	endfunction

	function automatic void add_step(step_kind_t kind, logic [4:0] size,
			mvm_pkg::mvm_op_t op, logic [3:0] row, logic [3:0] col, logic [31:0] value,
			logic [31:0] want);
		plan.push_back('{kind: kind, size: size, op: op, row: row, col: col,
			value: value, want: want});
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input mvm_pkg::mvm_op_t op, input logic [3:0] row,
			input logic [3:0] col, input logic [31:0] value,
			input step_kind_t kind = STEP_ITEM, input logic [31:0] want = '0);
		int gap;
		int got;
		gap = draw_gap(send_idle);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {value, col, row};
		s_axis_tuser = op;
		do @(posedge clk); while (!s_axis_tready);
		got = predict_item(op, row, col, value);
		case (kind)
			STEP_ITEM_ONE: begin
				awaited_results.push_back('{value: want,
					index: (op == mvm_pkg::OP_ROW_SUM) ? row : 4'd0, last: 1'b1});
			end
			STEP_ITEM_NONE: begin
			end
			default: begin
				for (int k = 0; k < got; k++) awaited_results.push_back(fresh_results[k]);
			end
		endcase
		@(negedge clk);
	endtask

	// the block may still be busy on an item with no result, so pad after the queue drains
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_order(input logic [4:0] size);
		wait_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = size;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		size_shadow = size;
	endtask

	// one order setting: fill what the order reads, then a random mix
	task automatic run_phase(input logic [4:0] size, input int op_total,
			input bit hold_here = 1'b0);
		int n;
		int pick;
		logic [3:0] r;
		logic [3:0] c;
		set_order(size);
		n = order_of(size);
		send_idle = ($urandom_range(0, 3) != 0);
		recv_idle = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (!mat_written[i*MAX_ORDER + j])
					send_item(mvm_pkg::OP_WRITE_MATRIX, 4'(i), 4'(j), rand_element());
		for (int j = 0; j < n; j++)
			if (!vec_written[j])
				send_item(mvm_pkg::OP_WRITE_VECTOR, 4'($urandom), 4'(j), rand_element());
		// long output stall while a multiply and the next items keep coming
		if (hold_here) begin
			hold_go = 1'b1;
			send_item(mvm_pkg::OP_MULTIPLY, 4'($urandom), 4'($urandom), $urandom);
		end
		repeat (op_total) begin
			pick = $urandom_range(0, 99);
			r = pick_index(n);
			c = pick_index(n);
			if (pick < 35)
				send_item(mvm_pkg::OP_WRITE_MATRIX, r, c, rand_element());
			else if (pick < 50)
				send_item(mvm_pkg::OP_WRITE_VECTOR, 4'($urandom), c, rand_element());
			else if (pick < 78)
				send_item(mvm_pkg::OP_MULTIPLY, 4'($urandom), 4'($urandom), $urandom);
			else
				send_item(mvm_pkg::OP_ROW_SUM, r, 4'($urandom), $urandom);
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: value %h index %0d last %b",
						m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tlast);
				fail_count++;
			end else begin
				head_result = awaited_results.pop_front();
				if (head_result.value !== m_axis_tdata[31:0] ||
						head_result.index !== m_axis_tdata[35:32] ||
						head_result.last !== m_axis_tlast) begin
					if (fail_count < 10)
						$display("result %0d: expected value %h index %0d last %b, ",
							result_count, head_result.value, head_result.index,
							head_result.last, "got value %h index %0d last %b",
							m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tlast);
					fail_count++;
				end
			end
			result_count++;
			stall_left = draw_gap(recv_idle);
		end
	end

	// result ready with per-item stalls and the long hold-off
	always @(negedge clk) begin
		m_axis_tready = !(output_hold || stall_left > 0);
		if (stall_left > 0) stall_left--;
	end

	// long output stall, started by the full order phase
	initial begin
		wait (hold_go);
		@(posedge clk);
		output_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		output_hold = 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		// order 1: saturation both ways, floor rounding, magnitude of the most negative entry
		add_step(STEP_SIZE, 5'd0, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd0, '0, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd0, mvm_pkg::SAT_MAX, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_VECTOR, 4'd15, 4'd0, mvm_pkg::SAT_MAX, '0);
		add_step(STEP_ITEM_ONE, '0, mvm_pkg::OP_MULTIPLY, 4'd15, 4'd15, 32'hFFFF_FFFF,
			mvm_pkg::SAT_MAX);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_VECTOR, 4'd0, 4'd0, mvm_pkg::SAT_MIN, '0);
		add_step(STEP_ITEM_ONE, '0, mvm_pkg::OP_MULTIPLY, 4'd0, 4'd0, '0, mvm_pkg::SAT_MIN);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd0, 32'hFFFF_FFFF, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_VECTOR, 4'd9, 4'd0, 32'h0000_0001, '0);
		add_step(STEP_ITEM_ONE, '0, mvm_pkg::OP_MULTIPLY, 4'd0, 4'd0, '0, 32'hFFFF_FFFF);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd0, mvm_pkg::SAT_MIN, '0);
		add_step(STEP_ITEM_ONE, '0, mvm_pkg::OP_ROW_SUM, 4'd0, 4'd0, '0, mvm_pkg::SAT_MAX);
		add_step(STEP_ITEM_NONE, '0, mvm_pkg::OP_ROW_SUM, 4'd15, 4'd15, '0, '0);
		// entries beyond the order are kept for later
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd1, 4'd1, mvm_pkg::SAT_MIN, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd1, 4'd0, mvm_pkg::SAT_MIN, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd1, '0, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_VECTOR, 4'd0, 4'd1, 32'h0001_0000, '0);
		// order 2: saturated sum of magnitudes, then products
		add_step(STEP_SIZE, 5'd2, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd0, '0, '0);
		add_step(STEP_ITEM_ONE, '0, mvm_pkg::OP_ROW_SUM, 4'd1, 4'd0, '0, mvm_pkg::SAT_MAX);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_MULTIPLY, 4'd0, 4'd0, '0, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd1, 32'hFFFF_0000, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_WRITE_VECTOR, 4'd3, 4'd0, 32'h0002_0000, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_MULTIPLY, 4'd0, 4'd0, '0, '0);
		add_step(STEP_SIZE, 5'd1, mvm_pkg::OP_WRITE_MATRIX, 4'd0, 4'd0, '0, '0);
		add_step(STEP_ITEM, '0, mvm_pkg::OP_MULTIPLY, 4'd0, 4'd0, '0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_SIZE)
				set_order(plan[i].size);
			else
				send_item(plan[i].op, plan[i].row, plan[i].col, plan[i].value,
					plan[i].kind, plan[i].want);
		end

		// mostly small orders, one medium, then the full order through both clamped codes
		for (int p = 0; p < 4; p++)
			run_phase((p == 2) ? 5'($urandom_range(7, 12)) : 5'($urandom_range(1, 6)), 8);
		run_phase(5'd31, 8, 1'b1);
		run_phase(5'd17, 3);
		run_phase(5'd16, 3);

		wait_idle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
